/* hw/rtl/char_class_expander_defines.svh */
// ----------------------------------------------------------------------------
// char_class_expander_defines.svh
// Assertion macros used by the char class expander top module.
// ----------------------------------------------------------------------------
`ifndef CHAR_CLASS_EXPANDER_DEFINES_SVH
`define CHAR_CLASS_EXPANDER_DEFINES_SVH

// Implication checked on every clock outside reset.
`define CCE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must never be seen.
`define CCE_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

`endif

/* hw/rtl/cce_pkg.sv */
// ----------------------------------------------------------------------------
// cce_pkg
// Types, codes and class tables for the char class expander.
// ----------------------------------------------------------------------------
package cce_pkg;

    localparam int MAX_OUT = 62;
    localparam int BUF_AW  = 6;
    localparam int NCLS    = 6;

    typedef enum logic [2:0] {
        MODE_IDLE, MODE_NORMAL, MODE_ESC, MODE_HELD, MODE_RANGE, MODE_LABEL
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PLAN, ST_GEN, ST_CHK, ST_RD, ST_OUT
    } ctl_state_t;

    localparam logic [2:0] CFG_CLOSE  = 3'd0;
    localparam logic [2:0] CFG_ESCAPE = 3'd1;
    localparam logic [2:0] CFG_RANGE  = 3'd2;
    localparam logic [2:0] CFG_CAP    = 3'd3;
    localparam logic [2:0] CFG_LABELS = 3'd4;

    localparam logic [1:0] STAT_RUNNING = 2'd0;
    localparam logic [1:0] STAT_CLOSE   = 2'd1;
    localparam logic [1:0] STAT_NUL     = 2'd2;
    localparam logic [1:0] STAT_BUDGET  = 2'd3;

    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;

    localparam logic [7:0] CLS_TEXT [0:5][0:9] = '{
        '{"[", ":", "u", "p", "p", "e", "r", ":", "]", 8'h00},
        '{"[", ":", "l", "o", "w", "e", "r", ":", "]", 8'h00},
        '{"[", ":", "d", "i", "g", "i", "t", ":", "]", 8'h00},
        '{"[", ":", "a", "l", "p", "h", "a", ":", "]", 8'h00},
        '{"[", ":", "a", "l", "n", "u", "m", ":", "]", 8'h00},
        '{"[", ":", "x", "d", "i", "g", "i", "t", ":", "]"}
    };
    localparam logic [3:0] CLS_LEN   [0:5] = '{4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd10};
    localparam logic [1:0] CLS_NRUNS [0:5] = '{2'd1, 2'd1, 2'd1, 2'd2, 2'd3, 2'd3};
    localparam logic [7:0] CLS_LO [0:5][0:2] = '{
        '{"A", 8'h00, 8'h00}, '{"a", 8'h00, 8'h00}, '{"0", 8'h00, 8'h00},
        '{"a", "A", 8'h00},   '{"a", "A", "0"},     '{"0", "A", "a"}
    };
    localparam logic [7:0] CLS_HI [0:5][0:2] = '{
        '{"Z", 8'h00, 8'h00}, '{"z", 8'h00, 8'h00}, '{"9", 8'h00, 8'h00},
        '{"z", "Z", 8'h00},   '{"z", "Z", "9"},     '{"9", "F", "f"}
    };

    typedef struct packed {
        logic accept;
        logic plan;
        logic emit;
        logic finish;
        logic rd;
        logic zero;
        logic pop;
    } cce_cmd_t;

    typedef struct packed {
        logic skip;
        logic gen_more;
        logic wcnt_zero;
        logic outcome_nz;
        logic out_last;
    } cce_sts_t;

    // 1 lower, 2 upper, 3 digit, 0 other
    function automatic logic [1:0] cce_kind(input logic [7:0] c);
        logic [1:0] k;
        k = 2'd0;
        if (c >= "a" && c <= "z") k = 2'd1;
        else if (c >= "A" && c <= "Z") k = 2'd2;
        else if (c >= "0" && c <= "9") k = 2'd3;
        return k;
    endfunction

endpackage

/* hw/rtl/char_class_expander.sv */
// ----------------------------------------------------------------------------
// char_class_expander
// Expands a bracket-expression spec, one char per transaction, into chars.
// ----------------------------------------------------------------------------
// channel | dir | handshake            | payload
// s_      | in  | s_valid / s_ready    | s_ch, s_start_req
// m_      | out | m_valid / m_ready    | m_out_char, m_char_valid, m_last, m_status
// cfg_    | in  | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// One input transaction at a time: accept, plan, then an emit loop (one char per
// cycle through the emit unit) and a finish step. A check state reads the first
// result; each result shows until m_ready takes it and the next one is read in
// the read state; a finished run with no results shows one empty marker result.
// A skipped input (idle or ended run) emits nothing. Reset is synchronous,
// active low; config returns to defaults. m_ready low simply holds the result.
// ----------------------------------------------------------------------------
`include "char_class_expander_defines.svh"

module char_class_expander #(
    parameter int LABEL_MAX = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ch,
    input  logic        s_start_req,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_char,
    output logic        m_char_valid,
    output logic        m_last,
    output logic [1:0]  m_status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import cce_pkg::*;

    cce_cmd_t cmd;
    cce_sts_t sts;

    // config writes are always accepted and registered
    assign cfg_ready = 1'b1;

    // sequencer: owns both handshakes
    cce_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // parser state, label store, emit unit, result buffer
    cce_datapath #(
        .LABEL_MAX (LABEL_MAX)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_ch         (s_ch),
        .s_start_req  (s_start_req),
        .cmd          (cmd),
        .sts          (sts),
        .m_out_char   (m_out_char),
        .m_char_valid (m_char_valid),
        .m_last       (m_last),
        .m_status     (m_status)
    );

    // input side is closed while results drain
    `CCE_ASSERT_NEVER(a_no_overlap, s_ready && m_valid, "input open during drain")
    // an empty marker result only reports a finished run
    `CCE_ASSERT_IMPL(a_marker, m_valid && !m_char_valid,
                     m_last && (m_status != STAT_RUNNING), "bad marker result")
    // more results follow a non-last transaction
    `CCE_ASSERT_NEXT(a_more, m_valid && m_ready && !m_last, !s_ready, "drain stopped early")

endmodule

/* hw/rtl/cce_ctrl.sv */
// ----------------------------------------------------------------------------
// cce_ctrl
// Sequencer: accept, plan, emit loop, finish, result drain.
// ----------------------------------------------------------------------------
module cce_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  cce_pkg::cce_sts_t sts,
    output cce_pkg::cce_cmd_t cmd
);
    import cce_pkg::*;

    ctl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_PLAN;
                end
            end
            ST_PLAN: begin
                if (sts.skip) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.plan   = 1'b1;
                    state_next = ST_GEN;
                end
            end
            ST_GEN: begin
                if (sts.gen_more) begin
                    cmd.emit = 1'b1;
                end else begin
                    cmd.finish = 1'b1;
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                if (!sts.wcnt_zero) begin
                    cmd.rd     = 1'b1;
                    state_next = ST_OUT;
                end else if (sts.outcome_nz) begin
                    cmd.zero   = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD: begin
                cmd.rd     = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    cmd.pop    = 1'b1;
                    state_next = sts.out_last ? ST_IDLE : ST_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/cce_datapath.sv */
// ----------------------------------------------------------------------------
// cce_datapath
// Config registers, parser state, label store, emit unit and result buffer.
// ----------------------------------------------------------------------------
module cce_datapath #(
    parameter int LABEL_MAX = 12
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic [7:0]        s_ch,
    input  logic              s_start_req,
    input  cce_pkg::cce_cmd_t cmd,
    output cce_pkg::cce_sts_t sts,
    output logic [7:0]        m_out_char,
    output logic              m_char_valid,
    output logic              m_last,
    output logic [1:0]        m_status
);
    import cce_pkg::*;

    localparam int LCW = $clog2(LABEL_MAX + 1);
    localparam int LAW = $clog2(LABEL_MAX);

    // config
    logic [7:0]  close_reg, close_next, esc_reg, esc_next, rng_reg, rng_next;
    logic [15:0] cap_reg, cap_next;
    logic        lab_en_reg, lab_en_next;

    // parser state
    mode_t           mode_reg, mode_next;
    logic [7:0]      held_reg, held_next;
    logic [LCW-1:0]  lcnt_reg, lcnt_next;
    logic [7:0]      last_lab_reg, last_lab_next;
    logic [NCLS-1:0] match_reg, match_next;
    logic [15:0]     budget_reg, budget_next;
    logic            ended_reg, ended_next;
    logic [1:0]      outcome_reg, outcome_next;
    logic [7:0]      ch_reg, ch_next;

    // plan and emit
    logic [7:0]      lo_reg [0:2];
    logic [7:0]      lo_next [0:2];
    logic [7:0]      hi_reg [0:2];
    logic [7:0]      hi_next [0:2];
    logic [1:0]      nruns_reg, nruns_next, run_idx_reg, run_idx_next;
    logic            lit_reg, lit_next, tok_reg, tok_next, post_reg, post_next;
    logic [LCW-1:0]  lit_n_reg, lit_n_next, lit_idx_reg, lit_idx_next;
    logic [7:0]      tok_ch_reg, tok_ch_next, cur_reg, cur_next;

    // result buffer
    logic [BUF_AW-1:0] wcnt_reg, wcnt_next, rd_idx_reg, rd_idx_next;
    logic              out_cv_reg, out_cv_next, out_last_reg, out_last_next;
    logic [7:0]        rdata_reg;
    logic [7:0]        res_mem [0:(1<<BUF_AW)-1];
    logic              res_we;
    logic [7:0]        emit_ch;

    // label store
    logic [7:0]     lab_mem [0:LABEL_MAX-1];
    logic           lab_init, lab_we;

    // label resolve
    logic [NCLS-1:0] m_upd, rv;
    logic [LCW-1:0]  rn;
    logic            hit;
    logic [2:0]      hit_idx;
    logic            closes;

    always_comb begin
        for (int i = 0; i < NCLS; i++) begin
            m_upd[i] = match_reg[i] && (lcnt_reg < LCW'(CLS_LEN[i]))
                       && (CLS_TEXT[i][lcnt_reg[3:0]] == ch_reg);
        end
        closes = (ch_reg == CH_RBRACK) && (last_lab_reg == CH_COLON);
        if (ch_reg != 8'h00 && lcnt_reg < LCW'(LABEL_MAX)) begin
            rv = m_upd;
            rn = lcnt_reg + LCW'(1);
        end else begin
            rv = match_reg;
            rn = lcnt_reg;
        end
        hit     = 1'b0;
        hit_idx = 3'd0;
        for (int i = NCLS - 1; i >= 0; i--) begin
            if (rv[i] && rn == LCW'(CLS_LEN[i])) begin
                hit     = 1'b1;
                hit_idx = 3'(i);
            end
        end
    end

    assign emit_ch = lit_reg ? lab_mem[lit_idx_reg[LAW-1:0]] : cur_reg;

    always_comb begin
        close_next  = close_reg;  esc_next = esc_reg; rng_next = rng_reg;
        cap_next    = cap_reg;    lab_en_next = lab_en_reg;
        mode_next   = mode_reg;   held_next = held_reg; lcnt_next = lcnt_reg;
        last_lab_next = last_lab_reg; match_next = match_reg;
        budget_next = budget_reg; ended_next = ended_reg;
        outcome_next = outcome_reg; ch_next = ch_reg;
        lo_next     = lo_reg;     hi_next = hi_reg;
        nruns_next  = nruns_reg;  run_idx_next = run_idx_reg;
        lit_next    = lit_reg;    tok_next = tok_reg; post_next = post_reg;
        lit_n_next  = lit_n_reg;  lit_idx_next = lit_idx_reg;
        tok_ch_next = tok_ch_reg; cur_next = cur_reg;
        wcnt_next   = wcnt_reg;   rd_idx_next = rd_idx_reg;
        out_cv_next = out_cv_reg; out_last_next = out_last_reg;
        res_we = 1'b0; lab_init = 1'b0; lab_we = 1'b0;

        if (cfg_valid) begin
            case (cfg_index)
                CFG_CLOSE:  close_next  = cfg_data[7:0];
                CFG_ESCAPE: esc_next    = cfg_data[7:0];
                CFG_RANGE:  rng_next    = cfg_data[7:0];
                CFG_CAP:    cap_next    = cfg_data;
                CFG_LABELS: lab_en_next = cfg_data[0];
                default: ;
            endcase
        end

        if (cmd.accept) begin
            ch_next      = s_ch;
            outcome_next = STAT_RUNNING;
            wcnt_next    = '0;
            rd_idx_next  = '0;
            if (s_start_req) begin
                mode_next   = MODE_NORMAL;
                held_next   = 8'h00;
                lcnt_next   = '0;
                budget_next = cap_reg;
                ended_next  = 1'b0;
            end
        end

        if (cmd.plan) begin
            nruns_next = 2'd0; lit_next = 1'b0; tok_next = 1'b0; post_next = 1'b0;
            run_idx_next = 2'd0; lit_idx_next = '0; tok_ch_next = ch_reg;
            lo_next = '{8'h00, 8'h00, 8'h00}; hi_next = '{8'h00, 8'h00, 8'h00};
            case (mode_reg)
                MODE_ESC: begin
                    nruns_next = 2'd1;
                    if (ch_reg == 8'h00) begin
                        lo_next[0] = esc_reg; hi_next[0] = esc_reg; tok_next = 1'b1;
                    end else begin
                        lo_next[0] = ch_reg; hi_next[0] = ch_reg; post_next = 1'b1;
                    end
                end
                MODE_HELD: begin
                    if (ch_reg != 8'h00 && ch_reg == rng_reg) begin
                        mode_next = MODE_RANGE;
                    end else if (lab_en_reg && held_reg == CH_LBRACK && ch_reg == CH_COLON) begin
                        lab_init      = 1'b1;
                        lcnt_next     = LCW'(2);
                        last_lab_next = CH_COLON;
                        match_next    = '1;
                        mode_next     = MODE_LABEL;
                    end else begin
                        nruns_next = 2'd1; lo_next[0] = held_reg; hi_next[0] = held_reg;
                        tok_next = 1'b1;
                    end
                end
                MODE_RANGE: begin
                    nruns_next = 2'd1; lo_next[0] = held_reg; hi_next[0] = held_reg;
                    if (ch_reg > held_reg && cce_kind(held_reg) != 2'd0
                        && cce_kind(held_reg) == cce_kind(ch_reg)) begin
                        hi_next[0] = ch_reg; post_next = 1'b1;
                    end else if (ch_reg > held_reg) begin
                        tok_next = 1'b1;
                    end else if (ch_reg < held_reg) begin
                        nruns_next = 2'd2; lo_next[1] = rng_reg; hi_next[1] = rng_reg;
                        tok_next = 1'b1;
                    end else begin
                        post_next = 1'b1;
                    end
                end
                MODE_LABEL: begin
                    if (ch_reg != 8'h00 && lcnt_reg < LCW'(LABEL_MAX)) begin
                        lab_we        = 1'b1;
                        lcnt_next     = lcnt_reg + LCW'(1);
                        last_lab_next = ch_reg;
                        match_next    = m_upd;
                    end else begin
                        tok_next = 1'b1;
                    end
                    if (tok_next || closes) begin
                        lcnt_next = '0;
                        post_next = 1'b1;
                        if (hit) begin
                            nruns_next = CLS_NRUNS[hit_idx];
                            for (int r = 0; r < 3; r++) begin
                                lo_next[r] = CLS_LO[hit_idx][r];
                                hi_next[r] = CLS_HI[hit_idx][r];
                            end
                        end else begin
                            lit_next   = 1'b1;
                            lit_n_next = rn;
                        end
                    end
                end
                default: begin
                    tok_next = 1'b1;
                end
            endcase
            cur_next = lo_next[0];
        end

        if (cmd.emit) begin
            if (budget_reg == 16'd0) begin
                ended_next = 1'b1; mode_next = MODE_IDLE; outcome_next = STAT_BUDGET;
            end else begin
                if (wcnt_reg < BUF_AW'(MAX_OUT)) begin
                    res_we    = 1'b1;
                    wcnt_next = wcnt_reg + BUF_AW'(1);
                end
                budget_next = budget_reg - 16'd1;
                if (budget_reg == 16'd1) begin
                    ended_next = 1'b1; mode_next = MODE_IDLE; outcome_next = STAT_BUDGET;
                end
            end
            if (lit_reg) begin
                lit_idx_next = lit_idx_reg + LCW'(1);
            end else if (cur_reg == hi_reg[run_idx_reg]) begin
                run_idx_next = run_idx_reg + 2'd1;
                if (run_idx_reg != 2'd2) cur_next = lo_reg[run_idx_reg + 2'd1];
            end else begin
                cur_next = cur_reg + 8'd1;
            end
        end

        if (cmd.finish && !ended_reg) begin
            if (tok_reg) begin
                if (budget_reg == 16'd0) begin
                    ended_next = 1'b1; mode_next = MODE_IDLE; outcome_next = STAT_BUDGET;
                end else if (tok_ch_reg == 8'h00) begin
                    ended_next = 1'b1; mode_next = MODE_IDLE; outcome_next = STAT_NUL;
                end else if (tok_ch_reg == close_reg) begin
                    ended_next = 1'b1; mode_next = MODE_IDLE; outcome_next = STAT_CLOSE;
                end else if (tok_ch_reg == esc_reg) begin
                    mode_next = MODE_ESC;
                end else begin
                    held_next = tok_ch_reg; mode_next = MODE_HELD;
                end
            end else if (post_reg) begin
                mode_next = MODE_NORMAL;
            end
        end

        if (cmd.rd) begin
            out_cv_next   = 1'b1;
            out_last_next = (rd_idx_reg == wcnt_reg - BUF_AW'(1));
        end
        if (cmd.zero) begin
            out_cv_next   = 1'b0;
            out_last_next = 1'b1;
        end
        if (cmd.pop) begin
            rd_idx_next = rd_idx_reg + BUF_AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            close_reg   <= 8'd93;
            esc_reg     <= 8'd92;
            rng_reg     <= 8'd45;
            cap_reg     <= 16'd256;
            lab_en_reg  <= 1'b1;
            mode_reg    <= MODE_IDLE;
            held_reg    <= 8'h00;
            lcnt_reg    <= '0;
            budget_reg  <= 16'd256;
            ended_reg   <= 1'b0;
            outcome_reg <= STAT_RUNNING;
            wcnt_reg    <= '0;
            rd_idx_reg  <= '0;
        end else begin
            close_reg   <= close_next;
            esc_reg     <= esc_next;
            rng_reg     <= rng_next;
            cap_reg     <= cap_next;
            lab_en_reg  <= lab_en_next;
            mode_reg    <= mode_next;
            held_reg    <= held_next;
            lcnt_reg    <= lcnt_next;
            budget_reg  <= budget_next;
            ended_reg   <= ended_next;
            outcome_reg <= outcome_next;
            wcnt_reg    <= wcnt_next;
            rd_idx_reg  <= rd_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_lab_reg <= last_lab_next;
        match_reg    <= match_next;
        ch_reg       <= ch_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        nruns_reg    <= nruns_next;
        run_idx_reg  <= run_idx_next;
        lit_reg      <= lit_next;
        tok_reg      <= tok_next;
        post_reg     <= post_next;
        lit_n_reg    <= lit_n_next;
        lit_idx_reg  <= lit_idx_next;
        tok_ch_reg   <= tok_ch_next;
        cur_reg      <= cur_next;
        out_cv_reg   <= out_cv_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (lab_init) begin
            lab_mem[0] <= CH_LBRACK;
            lab_mem[1] <= CH_COLON;
        end
        if (lab_we) begin
            lab_mem[lcnt_reg[LAW-1:0]] <= ch_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_we) begin
            res_mem[wcnt_reg] <= emit_ch;
        end
        if (cmd.rd) begin
            rdata_reg <= res_mem[rd_idx_reg];
        end else if (cmd.zero) begin
            rdata_reg <= 8'h00;
        end
    end

    assign sts.skip       = ended_reg || (mode_reg == MODE_IDLE);
    assign sts.gen_more   = !ended_reg && (lit_reg ? (lit_idx_reg < lit_n_reg)
                                                   : (run_idx_reg < nruns_reg));
    assign sts.wcnt_zero  = (wcnt_reg == '0);
    assign sts.outcome_nz = (outcome_reg != STAT_RUNNING);
    assign sts.out_last   = out_last_reg;

    assign m_out_char   = rdata_reg;
    assign m_char_valid = out_cv_reg;
    assign m_last       = out_last_reg;
    assign m_status     = outcome_reg;

endmodule
